[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define BDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bdc_pkg.sv]
// ----------------------------------------------------------------------------
// bdc_pkg
// shared types, constants and helpers for the ble dewhitening and crc check
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

	localparam logic [23:0] CRC_POLY     = 24'h00065B;
	localparam logic [7:0]  WHITEN_TAP   = 8'h11;
	localparam logic [7:0]  WHITEN_SEED  = 8'h02;
	localparam logic [5:0]  CHANNEL_RST  = 6'd37;

	typedef enum logic [2:0] {
		ST_BUSY     = 3'd0,
		ST_MATCH    = 3'd1,
		ST_MISMATCH = 3'd2,
		ST_BADLEN   = 3'd3,
		ST_IGNORED  = 3'd4
	} status_t;

	typedef struct packed {
		logic [23:0] computed_crc;
		logic [8:0]  byte_pos;
		logic [7:0]  natural_byte;
		logic [7:0]  plain_byte;
	} result_t;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7 - i];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/bdc_whiten.sv]
// ----------------------------------------------------------------------------
// bdc_whiten
// removes whitening from one byte and advances the 7-bit lfsr by eight bits
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_whiten
	import bdc_pkg::*;
(
	input  wire logic [7:0] lfsr_in,
	input  wire logic [7:0] byte_in,
	output logic      [7:0] plain_byte,
	output logic      [7:0] lfsr_out
);

	logic [7:0] lfsr_v;
	logic [7:0] data_v;

	always_comb begin
		lfsr_v = lfsr_in;
		data_v = byte_in;
		for (int i = 7; i >= 0; i--) begin
			if (lfsr_v[7]) begin
				lfsr_v    = lfsr_v ^ WHITEN_TAP;
				data_v[i] = ~data_v[i];
			end
			lfsr_v = {lfsr_v[6:0], 1'b0};
		end
		plain_byte = data_v;
		lfsr_out   = lfsr_v;
	end

endmodule

`default_nettype wire

[hdl/bdc_crc24.sv]
// ----------------------------------------------------------------------------
// bdc_crc24
// one byte of crc-24, air bit first (msb of the byte first)
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_crc24
	import bdc_pkg::*;
(
	input  wire logic [23:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [23:0] crc_out
);

	logic [23:0] crc_v;
	logic        top_v;

	always_comb begin
		crc_v = crc_in;
		top_v = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			top_v = crc_v[23];
			crc_v = {crc_v[22:0], 1'b0};
			if (top_v != data[i]) begin
				crc_v = crc_v ^ CRC_POLY;
			end
		end
		crc_out = crc_v;
	end

endmodule

`default_nettype wire

[hdl/ble_dewhiten_crc24_check_top.sv]
// ----------------------------------------------------------------------------
// ble_dewhiten_crc24_check_top: ble pdu dewhitening and crc-24 check
// the result is registered: input reg, then result reg (an output stall holds it)
// throughput: one byte per cycle unless stalled; lfsr/crc update is combinational
// reset: arst_n async low clears handshake and packet state, channel to 37
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ble_dewhiten_crc24_check_top
	import bdc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic [5:0]  cfg_wdata,     // rf_channel

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // byte_in[7:0], crc_init[31:8]
	input  wire logic        s_axis_tuser,  // start_req[0]

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,  // plain_byte[7:0], natural_byte[15:8],
	                                        // byte_pos[24:16], computed_crc[48:25], zero
	output logic             m_axis_tlast,  // final_res
	output logic [2:0]       m_axis_tuser   // status[2:0]
);

	logic [5:0]  chan_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic [23:0] init_s1;

	logic [7:0]  lfsr_q;
	logic [23:0] crc_q;
	logic [23:0] rcv_q;
	logic [8:0]  pos_q;
	logic [7:0]  len_q;
	logic        act_q;

	logic [7:0]  eff_lfsr;
	logic [23:0] eff_crc;
	logic [23:0] eff_rcv;
	logic [8:0]  eff_pos;
	logic [7:0]  eff_len;
	logic        eff_act;

	logic [7:0]  plain;
	logic [7:0]  natural;
	logic [7:0]  lfsr_nx;
	logic [23:0] crc_step;
	logic [23:0] crc_nx;
	logic [23:0] rcv_nx;
	logic [7:0]  len_nx;
	logic        in_data;
	logic        fin;
	status_t     status;
	logic [9:0]  pos_w;
	logic [9:0]  len_w;

	logic        advance;
	result_t     res;
	result_t     res_q;
	logic        last_q;
	status_t     status_q;

	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= CHANNEL_RST;
		end else if (cfg_we) begin
			chan_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata[7:0];
			init_s1  <= s_axis_tdata[31:8];
			start_s1 <= s_axis_tuser;
		end
	end

	// packet state as seen by this byte
	always_comb begin
		if (start_s1) begin
			eff_lfsr = rev8({2'b00, chan_q}) | WHITEN_SEED;
			eff_crc  = init_s1;
			eff_rcv  = 24'd0;
			eff_pos  = 9'd0;
			eff_len  = 8'd0;
			eff_act  = 1'b1;
		end else begin
			eff_lfsr = lfsr_q;
			eff_crc  = crc_q;
			eff_rcv  = rcv_q;
			eff_pos  = pos_q;
			eff_len  = len_q;
			eff_act  = act_q;
		end
	end

	bdc_whiten u_whiten (
		.lfsr_in    (eff_lfsr),
		.byte_in    (byte_s1),
		.plain_byte (plain),
		.lfsr_out   (lfsr_nx)
	);

	bdc_crc24 u_crc (
		.crc_in  (eff_crc),
		.data    (plain),
		.crc_out (crc_step)
	);

	always_comb begin
		natural = rev8(plain);
		pos_w   = {1'b0, eff_pos};
		len_w   = {2'b00, eff_len};
		in_data = (pos_w < 10'd2) || (pos_w < len_w + 10'd2);
		crc_nx  = in_data ? crc_step : eff_crc;
		rcv_nx  = in_data ? eff_rcv : {eff_rcv[15:0], plain};
		len_nx  = eff_len;
		fin     = 1'b0;
		status  = ST_BUSY;
		if (pos_w == 10'd1) begin
			len_nx = natural;
			if (natural < 8'd2) begin
				fin    = 1'b1;
				status = ST_BADLEN;
			end
		end else if (pos_w >= 10'd2 && pos_w == len_w + 10'd4) begin
			fin    = 1'b1;
			status = (rcv_nx == crc_nx) ? ST_MATCH : ST_MISMATCH;
		end

		if (eff_act) begin
			res.plain_byte   = plain;
			res.natural_byte = natural;
			res.byte_pos     = eff_pos;
			res.computed_crc = fin ? crc_nx : 24'd0;
		end else begin
			res    = '0;
			fin    = 1'b0;
			status = ST_IGNORED;
		end
	end

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= 8'd0;
			crc_q  <= 24'd0;
			rcv_q  <= 24'd0;
			pos_q  <= 9'd0;
			len_q  <= 8'd0;
			act_q  <= 1'b0;
		end else if (advance && eff_act) begin
			lfsr_q <= lfsr_nx;
			crc_q  <= crc_nx;
			rcv_q  <= rcv_nx;
			pos_q  <= eff_pos + 9'd1;
			len_q  <= len_nx;
			act_q  <= !fin;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q    <= res;
			last_q   <= fin;
			status_q <= status;
		end
	end

	assign m_axis_tdata = {7'd0, res_q};
	assign m_axis_tlast = last_q;
	assign m_axis_tuser = status_q;

	`BDC_ASSERT_IMP(a_last_has_verdict, clk, arst_n, m_axis_tvalid && m_axis_tlast,
		m_axis_tuser == ST_MATCH || m_axis_tuser == ST_MISMATCH || m_axis_tuser == ST_BADLEN,
		"final result without a verdict status")
	`BDC_ASSERT_IMP(a_ignored_is_empty, clk, arst_n,
		m_axis_tvalid && m_axis_tuser == ST_IGNORED,
		m_axis_tdata == 56'd0 && !m_axis_tlast, "ignored byte carries data")
	`BDC_ASSERT_NXT(a_advance_shows_result, clk, arst_n, advance, m_axis_tvalid,
		"processed byte did not reach the result register")

endmodule

`default_nettype wire
